>>> hdl/evr_pkg.sv
// Shared types, constants and table functions of the Euler vector rotator.
package evr_pkg;

  localparam int COORD_W     = 32;
  localparam int ANGLE_W     = 16;
  localparam int TRIG_W      = 16;
  localparam int ROM_W       = 15;
  localparam int PROD_W      = 48;
  localparam int SUM_W       = 49;
  localparam int FRAC_SHIFT  = 15;
  localparam int PIPE_STAGES = 8;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] Q15_ONE     = 64'd32767;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [ANGLE_W-1:0]        angle_t;
  typedef logic signed [TRIG_W-1:0]  trig_t;

  // Load enables of the two register stages inside a pipelined unit.
  typedef struct packed {
    logic load_a;
    logic load_b;
  } pipe_ctl_t;

  // One quarter-wave table entry: Taylor series of sin(x), x in Q30 radians,
  // scaled to Q1.15 with round half up and clamped to 32767.
  function automatic logic [ROM_W-1:0] quarter_entry(input logic [63:0] x);
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        r;
    term = x;
    sum  = signed'(x);
    for (int k = 1; k <= 8; k++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = term / 64'((2 * k) * (2 * k + 1));
      if ((k & 1) == 1) begin
        sum = sum - signed'(term);
      end else begin
        sum = sum + signed'(term);
      end
    end
    if (sum < 0) begin
      sum = '0;
    end
    r = (64'(sum) * Q15_ONE + (64'd1 << 29)) >> 30;
    if (r > Q15_ONE) begin
      r = Q15_ONE;
    end
    return r[ROM_W-1:0];
  endfunction

  // Round half up, drop the Q15 fraction and saturate to the coordinate range.
  function automatic coord_t round_sat(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0]           biased;
    logic signed [SUM_W-FRAC_SHIFT-1:0] sh;
    biased = v + SUM_W'(64'd1 << (FRAC_SHIFT - 1));
    sh     = biased[SUM_W-1:FRAC_SHIFT];
    if (sh[SUM_W-FRAC_SHIFT-1:COORD_W-1] == '0 ||
        sh[SUM_W-FRAC_SHIFT-1:COORD_W-1] == '1) begin
      return sh[COORD_W-1:0];
    end else if (sh[SUM_W-FRAC_SHIFT-1]) begin
      return {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      return {1'b0, {(COORD_W-1){1'b1}}};
    end
  endfunction

endpackage

>>> hdl/evr_in_if.sv
// Input channel of the rotator: point coordinates and three binary angles.
interface evr_in_if;
  import evr_pkg::*;

  logic   valid;
  logic   ready;
  coord_t pos_x;
  coord_t pos_y;
  coord_t pos_z;
  angle_t angle_x;
  angle_t angle_y;
  angle_t angle_z;

  modport source (output valid, output pos_x, output pos_y, output pos_z,
                  output angle_x, output angle_y, output angle_z, input ready);
  modport sink (input valid, input pos_x, input pos_y, input pos_z,
                input angle_x, input angle_y, input angle_z, output ready);
endinterface

>>> hdl/evr_out_if.sv
// Result channel of the rotator: the rotated point.
interface evr_out_if;
  import evr_pkg::*;

  logic   valid;
  logic   ready;
  coord_t out_x;
  coord_t out_y;
  coord_t out_z;

  modport source (output valid, output out_x, output out_y, output out_z, input ready);
  modport sink (input valid, input out_x, input out_y, input out_z, output ready);
endinterface

>>> hdl/evr_trig.sv
// Two-stage sine and cosine lookup from a quarter-wave Q1.15 table.
module evr_trig #(
  parameter int ANGLE_BITS       = 16,
  parameter int SINE_TABLE_DEPTH = 256
) (
  input  logic               clk,
  input  evr_pkg::pipe_ctl_t ctl,
  input  evr_pkg::angle_t    angle_i,
  output evr_pkg::trig_t     sin_o,
  output evr_pkg::trig_t     cos_o
);
  import evr_pkg::*;

  localparam int FW = ANGLE_BITS - 2;
  localparam int IW = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int PW = FW + IW;
  localparam logic [ANGLE_BITS-1:0] QUARTER = {2'b01, {FW{1'b0}}};

  typedef struct packed {
    logic          neg;
    logic [IW-1:0] idx;
  } lookup_t;

  logic [ROM_W-1:0] quarter_rom [SINE_TABLE_DEPTH+1];

  for (genvar gi = 0; gi <= SINE_TABLE_DEPTH; gi++) begin : g_rom
    localparam logic [63:0] XQ = (HALF_PI_Q30 * 64'(gi)) / 64'(SINE_TABLE_DEPTH);
    assign quarter_rom[gi] = quarter_entry(XQ);
  end

  // Quadrant picks the table direction and the sign; the fraction scales to an index.
  function automatic lookup_t locate(input logic [ANGLE_BITS-1:0] a);
    logic [PW-1:0] prod;
    logic [IW-1:0] idx;
    prod = PW'(a[FW-1:0]) * PW'(SINE_TABLE_DEPTH);
    idx  = prod[PW-1:FW];
    if (a[FW]) begin
      idx = IW'(SINE_TABLE_DEPTH) - idx;
    end
    return '{neg: a[FW+1], idx: idx};
  endfunction

  logic [ANGLE_BITS-1:0] ang;
  lookup_t               sin_lk_r;
  lookup_t               cos_lk_r;
  trig_t                 sin_mag;
  trig_t                 cos_mag;
  trig_t                 sin_r;
  trig_t                 cos_r;
  trig_t                 sin_nxt;
  trig_t                 cos_nxt;

  assign ang = ANGLE_BITS'(angle_i);

  always_comb begin
    sin_mag = signed'({1'b0, quarter_rom[sin_lk_r.idx]});
    cos_mag = signed'({1'b0, quarter_rom[cos_lk_r.idx]});
    sin_nxt = sin_lk_r.neg ? -sin_mag : sin_mag;
    cos_nxt = cos_lk_r.neg ? -cos_mag : cos_mag;
  end

  always_ff @(posedge clk) begin
    if (ctl.load_a) begin
      sin_lk_r <= locate(ang);
      cos_lk_r <= locate(ang + QUARTER);
    end
    if (ctl.load_b) begin
      sin_r <= sin_nxt;
      cos_r <= cos_nxt;
    end
  end

  assign sin_o = sin_r;
  assign cos_o = cos_r;
endmodule

>>> hdl/evr_rot.sv
// Two-stage plane rotation: a' = a*c - b*s, b' = a*s + b*c, rounded and saturated.
module evr_rot (
  input  logic               clk,
  input  evr_pkg::pipe_ctl_t ctl,
  input  evr_pkg::coord_t    a_i,
  input  evr_pkg::coord_t    b_i,
  input  evr_pkg::trig_t     sin_i,
  input  evr_pkg::trig_t     cos_i,
  output evr_pkg::coord_t    a_o,
  output evr_pkg::coord_t    b_o
);
  import evr_pkg::*;

  logic signed [PROD_W-1:0] pac_r;
  logic signed [PROD_W-1:0] pbs_r;
  logic signed [PROD_W-1:0] pas_r;
  logic signed [PROD_W-1:0] pbc_r;
  logic signed [SUM_W-1:0]  sum_a;
  logic signed [SUM_W-1:0]  sum_b;
  coord_t                   a_r;
  coord_t                   b_r;

  always_comb begin
    sum_a = SUM_W'(pac_r) - SUM_W'(pbs_r);
    sum_b = SUM_W'(pas_r) + SUM_W'(pbc_r);
  end

  always_ff @(posedge clk) begin
    if (ctl.load_a) begin
      pac_r <= PROD_W'(a_i) * PROD_W'(cos_i);
      pbs_r <= PROD_W'(b_i) * PROD_W'(sin_i);
      pas_r <= PROD_W'(a_i) * PROD_W'(sin_i);
      pbc_r <= PROD_W'(b_i) * PROD_W'(cos_i);
    end
    if (ctl.load_b) begin
      a_r <= round_sat(sum_a);
      b_r <= round_sat(sum_b);
    end
  end

  assign a_o = a_r;
  assign b_o = b_r;
endmodule

>>> hdl/euler_vector_rotate.sv
// Top level of the Euler X-Y-Z point rotator.
//
// Each input beat carries a point (three signed Q16.16 coordinates) and three
// binary angles, where 2^ANGLE_BITS is a full turn; only the low ANGLE_BITS bits
// of an angle count. The point is rotated about X, then Y, then Z, and the rotated
// point leaves as one output beat. Sine and cosine come from a quarter-wave table
// of SINE_TABLE_DEPTH+1 entries in Q1.15 without interpolation, so a zero angle
// scales a coordinate by 32767/32768. Every rotation rounds half up and saturates
// to the 32-bit range; overflow is not flagged. The block takes one beat per
// cycle while the output is not stalled. A result passes two stages for the
// first table lookup, then two per rotation (multiply, then round and saturate),
// and the lookups for the Y and Z angles run alongside the rotation before them.
// Every stage carries its own valid bit and loads whenever it is empty or the
// stage after it moves, so a stalled output fills the bubbles behind it before
// input ready drops. The last stage is the output register. No state survives an
// item, and there are no configuration registers.
module euler_vector_rotate #(
  parameter int ANGLE_BITS       = 16,
  parameter int SINE_TABLE_DEPTH = 256
) (
  input logic      clk,
  input logic      rst_n,
  evr_in_if.sink   in_chan,
  evr_out_if.source out_chan
);
  import evr_pkg::*;

  // Per-stage valid bits and load enables; enable k+1 is the move of stage k.
  logic [PIPE_STAGES:1]   v_r;
  logic [PIPE_STAGES:1]   v_nxt;
  logic [PIPE_STAGES+1:1] en;

  always_comb begin
    en[PIPE_STAGES+1] = out_chan.ready;
    for (int k = PIPE_STAGES; k >= 1; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
    v_nxt = v_r;
    if (en[1]) begin
      v_nxt[1] = in_chan.valid;
    end
    for (int k = 2; k <= PIPE_STAGES; k++) begin
      if (en[k]) begin
        v_nxt[k] = v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_chan.ready = en[1];

  // Outputs of the lookup and rotation units.
  trig_t  sin_x, cos_x, sin_y, cos_y, sin_z, cos_z;
  coord_t y4, z4, z6, x6, x8, y8;

  // Coordinates and angles that wait beside the units for their turn.
  coord_t x1_r, x2_r, x3_r, x4_r;
  coord_t y1_r, y2_r, y5_r, y6_r;
  coord_t z1_r, z2_r, z7_r, z8_r;
  angle_t ay1_r, ay2_r;
  angle_t az1_r, az2_r, az3_r, az4_r;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      x1_r  <= in_chan.pos_x;
      y1_r  <= in_chan.pos_y;
      z1_r  <= in_chan.pos_z;
      ay1_r <= in_chan.angle_y;
      az1_r <= in_chan.angle_z;
    end
    if (en[2]) begin
      x2_r  <= x1_r;
      y2_r  <= y1_r;
      z2_r  <= z1_r;
      ay2_r <= ay1_r;
      az2_r <= az1_r;
    end
    if (en[3]) begin
      x3_r  <= x2_r;
      az3_r <= az2_r;
    end
    if (en[4]) begin
      x4_r  <= x3_r;
      az4_r <= az3_r;
    end
    if (en[5]) begin
      y5_r <= y4;
    end
    if (en[6]) begin
      y6_r <= y5_r;
    end
    if (en[7]) begin
      z7_r <= z6;
    end
    if (en[8]) begin
      z8_r <= z7_r;
    end
  end

  // Stage controls of the units.
  pipe_ctl_t ctl_s12, ctl_s34, ctl_s56, ctl_s78;

  assign ctl_s12 = '{load_a: en[1], load_b: en[2]};
  assign ctl_s34 = '{load_a: en[3], load_b: en[4]};
  assign ctl_s56 = '{load_a: en[5], load_b: en[6]};
  assign ctl_s78 = '{load_a: en[7], load_b: en[8]};

  evr_trig #(.ANGLE_BITS(ANGLE_BITS), .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_trig_x (
    .clk(clk), .ctl(ctl_s12), .angle_i(in_chan.angle_x), .sin_o(sin_x), .cos_o(cos_x)
  );

  evr_trig #(.ANGLE_BITS(ANGLE_BITS), .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_trig_y (
    .clk(clk), .ctl(ctl_s34), .angle_i(ay2_r), .sin_o(sin_y), .cos_o(cos_y)
  );

  evr_trig #(.ANGLE_BITS(ANGLE_BITS), .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_trig_z (
    .clk(clk), .ctl(ctl_s56), .angle_i(az4_r), .sin_o(sin_z), .cos_o(cos_z)
  );

  // About X: y' = y*c - z*s, z' = y*s + z*c.
  evr_rot u_rot_x (
    .clk(clk), .ctl(ctl_s34), .a_i(y2_r), .b_i(z2_r),
    .sin_i(sin_x), .cos_i(cos_x), .a_o(y4), .b_o(z4)
  );

  // About Y: z' = z*c - x*s, x' = z*s + x*c.
  evr_rot u_rot_y (
    .clk(clk), .ctl(ctl_s56), .a_i(z4), .b_i(x4_r),
    .sin_i(sin_y), .cos_i(cos_y), .a_o(z6), .b_o(x6)
  );

  // About Z: x' = x*c - y*s, y' = x*s + y*c. Its result registers feed the port.
  evr_rot u_rot_z (
    .clk(clk), .ctl(ctl_s78), .a_i(x6), .b_i(y6_r),
    .sin_i(sin_z), .cos_i(cos_z), .a_o(x8), .b_o(y8)
  );

  assign out_chan.valid = v_r[PIPE_STAGES];
  assign out_chan.out_x = x8;
  assign out_chan.out_y = y8;
  assign out_chan.out_z = z8_r;
endmodule

>>> hdl/evr_checker.sv
// Port-level checks of the rotator and their bind to the top level.
module evr_port_checks (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input evr_pkg::coord_t out_x,
  input evr_pkg::coord_t out_y,
  input evr_pkg::coord_t out_z
);
  import evr_pkg::*;

  localparam int CW = $clog2(PIPE_STAGES + 1) + 1;

  logic          in_fire;
  logic          out_fire;
  logic [CW-1:0] occ_r;
  logic [CW-1:0] occ_nxt;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  always_comb begin
    occ_nxt = occ_r;
    if (in_fire && !out_fire) begin
      occ_nxt = occ_r + CW'(1);
    end else if (!in_fire && out_fire) begin
      occ_nxt = occ_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  // A held result stays valid and unchanged until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y) &&
    $stable(out_z))
    else $error("result beat changed while stalled");

  // With the output drained every cycle, no stage can block the input.
  a_no_block: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input blocked while output is ready");

  // The pipeline never holds more beats than it has stages, and never shows a
  // result that was not put in.
  a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
    (occ_r <= CW'(PIPE_STAGES)) && (!out_valid || occ_r != '0))
    else $error("beats in flight out of range");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");
endmodule

bind euler_vector_rotate evr_port_checks u_evr_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_valid(in_chan.valid),
  .in_ready(in_chan.ready),
  .out_valid(out_chan.valid),
  .out_ready(out_chan.ready),
  .out_x(out_chan.out_x),
  .out_y(out_chan.out_y),
  .out_z(out_chan.out_z)
);
